FILE: hw/rtl/srrw_pkg.sv
// ----------------------------------------------------------------------------
// srrw_pkg: shared types and constants of the selective repeat receive window
// Store entry layout, result word layout, sequencer states and fixed limits.
// ----------------------------------------------------------------------------
package srrw_pkg;

    localparam int WINDOW_DEPTH_DEF = 64;   // default store depth
    localparam int MAX_RELEASE      = 64;   // releases per input word at most
    localparam int RCNT_W           = $clog2(MAX_RELEASE + 1);
    localparam int SEQ_W            = 32;
    localparam int STAMP_W          = 32;
    localparam int AFTER_W          = 8;
    localparam int PREF_W           = 16;
    localparam int PLEN_W           = 11;
    localparam int WIN_W            = 7;
    localparam logic [WIN_W-1:0] WINDOW_RESET = 7'd64;

    // one store entry: present mark plus what a release needs
    typedef struct packed {
        logic              present;
        logic [PREF_W-1:0] pref;
        logic [PLEN_W-1:0] plen;
        logic              msg_end;
    } srrw_entry_t;

    // one result word
    typedef struct packed {
        logic               ack_valid;
        logic [SEQ_W-1:0]   ack_seq;
        logic [STAMP_W-1:0] ack_stamp;
        logic               deliver_valid;
        logic [SEQ_W-1:0]   deliver_seq;
        logic [PREF_W-1:0]  deliver_ref;
        logic [PLEN_W-1:0]  deliver_len;
        logic               message_end;
        logic               out_of_window;
        logic               duplicate;
        logic               last;
    } srrw_res_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_LOOKUP,
        ST_RELEASE,
        ST_DONE
    } srrw_state_t;

endpackage

FILE: hw/rtl/selective_repeat_receive_window.sv
// Flow: ST_CHECK classifies an accepted fragment. A dropped fragment or a repeat
//   below next expected goes to ST_DONE; an in-window one passes ST_LOOKUP and
//   reaches ST_RELEASE, which releases stored fragments in order. One fragment at a time.
// A new fragment is taken only once the last word of the previous one is in the
//   output register; one store read and one write per released entry.
// Reset (aresetn low, synchronous): next expected = 0, window = 64, then a
//   sweep clears every store slot; no input is taken during it.
// ----------------------------------------------------------------------------
// selective_repeat_receive_window: receive reorder window
// Classifies push fragments against the window, acks every one below the window
// end, stores new ones in a slot memory and releases stored fragments in sequence order.
// ----------------------------------------------------------------------------
module selective_repeat_receive_window
    import srrw_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,

    // window size register write
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [WIN_W-1:0]   cfg_window_size,

    // fragment descriptor in
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [SEQ_W-1:0]   s_frag_seq,
    input  logic [STAMP_W-1:0] s_frag_stamp,
    input  logic [AFTER_W-1:0] s_frags_after,
    input  logic [PREF_W-1:0]  s_payload_ref,
    input  logic [PLEN_W-1:0]  s_payload_len,

    // result words out
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_ack_valid,
    output logic [SEQ_W-1:0]   m_ack_seq,
    output logic [STAMP_W-1:0] m_ack_stamp,
    output logic               m_deliver_valid,
    output logic [SEQ_W-1:0]   m_deliver_seq,
    output logic [PREF_W-1:0]  m_deliver_ref,
    output logic [PLEN_W-1:0]  m_deliver_len,
    output logic               m_message_end,
    output logic               m_out_of_window,
    output logic               m_duplicate,
    output logic               m_last
);

    localparam int SLOT_W = $clog2(WINDOW_DEPTH);
    localparam logic [SLOT_W:0]   DEPTH_EXT = (SLOT_W+1)'(WINDOW_DEPTH);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_DEPTH - 1);

    // ------------------------------------------------------------------
    // fragment store: one write and one registered read per cycle
    // ------------------------------------------------------------------
    srrw_entry_t mem [WINDOW_DEPTH];
    srrw_entry_t mem_rd_reg;
    logic              mem_we;
    logic [SLOT_W-1:0] mem_wa;
    srrw_entry_t       mem_wd;
    logic              mem_re;
    logic [SLOT_W-1:0] mem_ra;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            mem_rd_reg <= mem[mem_ra];
        end
    end

    // ------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------
    srrw_state_t        state_reg, state_next;
    logic [SLOT_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [WIN_W-1:0]   window_size_reg, window_size_next;
    logic [SEQ_W-1:0]   ne_reg, ne_next;              // next expected seq
    logic [SLOT_W-1:0]  ne_slot_reg, ne_slot_next;    // ne mod depth
    logic [31:0]        dropped_count_reg, dropped_count_next;
    logic [RCNT_W-1:0]  rel_cnt_reg, rel_cnt_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic               fwd_reg, fwd_next;            // write-to-read bypass
    srrw_entry_t        fwd_data_reg, fwd_data_next;
    srrw_res_t          pend_reg, pend_next;          // word under assembly
    srrw_res_t          out_reg, out_next;
    logic               m_valid_reg, m_valid_next;

    logic [SEQ_W-1:0]   in_seq_reg, in_seq_next;
    logic [STAMP_W-1:0] in_stamp_reg, in_stamp_next;
    logic [AFTER_W-1:0] in_after_reg, in_after_next;
    logic [PREF_W-1:0]  in_ref_reg, in_ref_next;
    logic [PLEN_W-1:0]  in_len_reg, in_len_next;

    // ------------------------------------------------------------------
    // window arithmetic
    // ------------------------------------------------------------------
    logic [SEQ_W:0]    win_eff;
    logic [SEQ_W:0]    limit;
    logic [SEQ_W-1:0]  seq_diff;
    logic [SLOT_W:0]   slot_sum;
    logic [SLOT_W-1:0] slot_calc;
    logic [SLOT_W-1:0] ne_slot_adv;
    logic              out_free;
    srrw_entry_t       cur_entry;
    logic              rel_go;
    srrw_res_t         rel_word;

    // window clipped to store depth; limit formed without wrap
    assign win_eff = ({26'd0, window_size_reg} > (SEQ_W+1)'(WINDOW_DEPTH))
                   ? (SEQ_W+1)'(WINDOW_DEPTH) : {26'd0, window_size_reg};
    assign limit   = {1'b0, ne_reg} + win_eff;

    // in-window seq is less than depth past ne: one conditional subtract
    assign seq_diff  = in_seq_reg - ne_reg;
    assign slot_sum  = {1'b0, ne_slot_reg} + {1'b0, seq_diff[SLOT_W-1:0]};
    assign slot_calc = (slot_sum >= DEPTH_EXT) ? SLOT_W'(slot_sum - DEPTH_EXT)
                                               : slot_sum[SLOT_W-1:0];

    // slot of ne+1; seq 0 is always slot 0 after the wrap
    assign ne_slot_adv = (ne_reg == '1)          ? '0 :
                         (ne_slot_reg == LAST_SLOT) ? '0 :
                         ne_slot_reg + SLOT_W'(1);

    assign out_free  = !m_valid_reg || m_ready;
    assign cur_entry = fwd_reg ? fwd_data_reg : mem_rd_reg;
    assign rel_go    = cur_entry.present && (rel_cnt_reg != RCNT_W'(MAX_RELEASE));

    always_comb begin
        rel_word               = '0;
        rel_word.deliver_valid = 1'b1;
        rel_word.deliver_seq   = ne_reg;
        rel_word.deliver_ref   = cur_entry.pref;
        rel_word.deliver_len   = cur_entry.plen;
        rel_word.message_end   = cur_entry.msg_end;
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next         = state_reg;
        clr_cnt_next       = clr_cnt_reg;
        window_size_next   = window_size_reg;
        ne_next            = ne_reg;
        ne_slot_next       = ne_slot_reg;
        dropped_count_next = dropped_count_reg;
        rel_cnt_next       = rel_cnt_reg;
        slot_next          = slot_reg;
        fwd_next           = fwd_reg;
        fwd_data_next      = fwd_data_reg;
        pend_next          = pend_reg;
        out_next           = out_reg;
        m_valid_next       = m_valid_reg && !m_ready;
        in_seq_next        = in_seq_reg;
        in_stamp_next      = in_stamp_reg;
        in_after_next      = in_after_reg;
        in_ref_next        = in_ref_reg;
        in_len_next        = in_len_reg;
        mem_we             = 1'b0;
        mem_wa             = '0;
        mem_wd             = '0;
        mem_re             = 1'b0;
        mem_ra             = '0;
        s_ready            = 1'b0;

        if (cfg_valid) begin
            window_size_next = cfg_window_size;
        end

        case (state_reg)
            ST_CLEAR: begin
                mem_we       = 1'b1;
                mem_wa       = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + SLOT_W'(1);
                if (clr_cnt_reg == LAST_SLOT) begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    in_seq_next   = s_frag_seq;
                    in_stamp_next = s_frag_stamp;
                    in_after_next = s_frags_after;
                    in_ref_next   = s_payload_ref;
                    in_len_next   = s_payload_len;
                    state_next    = ST_CHECK;
                end
            end

            ST_CHECK: begin
                pend_next = '0;
                if ({1'b0, in_seq_reg} >= limit) begin
                    pend_next.out_of_window = 1'b1;
                    dropped_count_next      = dropped_count_reg + 32'd1;
                    state_next              = ST_DONE;
                end else begin
                    pend_next.ack_valid = 1'b1;
                    pend_next.ack_seq   = in_seq_reg;
                    pend_next.ack_stamp = in_stamp_reg;
                    if (in_seq_reg < ne_reg) begin
                        pend_next.duplicate = 1'b1;
                        state_next          = ST_DONE;
                    end else begin
                        mem_re     = 1'b1;
                        mem_ra     = slot_calc;
                        slot_next  = slot_calc;
                        state_next = ST_LOOKUP;
                    end
                end
            end

            ST_LOOKUP: begin
                // fetch the ne slot; bypass if this cycle's store hits it
                mem_re       = 1'b1;
                mem_ra       = ne_slot_reg;
                rel_cnt_next = '0;
                fwd_next     = 1'b0;
                if (mem_rd_reg.present) begin
                    pend_next.duplicate = 1'b1;
                end else begin
                    mem_we                = 1'b1;
                    mem_wa                = slot_reg;
                    mem_wd.present        = 1'b1;
                    mem_wd.pref           = in_ref_reg;
                    mem_wd.plen           = in_len_reg;
                    mem_wd.msg_end        = (in_after_reg == '0);
                    fwd_next              = (slot_reg == ne_slot_reg);
                    fwd_data_next         = mem_wd;
                end
                state_next = ST_RELEASE;
            end

            ST_RELEASE: begin
                if (rel_go) begin
                    if (rel_cnt_reg == '0 || out_free) begin
                        if (rel_cnt_reg == '0) begin
                            // first release rides on the ack word
                            pend_next.deliver_valid = 1'b1;
                            pend_next.deliver_seq   = rel_word.deliver_seq;
                            pend_next.deliver_ref   = rel_word.deliver_ref;
                            pend_next.deliver_len   = rel_word.deliver_len;
                            pend_next.message_end   = rel_word.message_end;
                        end else begin
                            out_next      = pend_reg;
                            out_next.last = 1'b0;
                            m_valid_next  = 1'b1;
                            pend_next     = rel_word;
                        end
                        mem_we       = 1'b1;
                        mem_wa       = ne_slot_reg;
                        mem_re       = 1'b1;
                        mem_ra       = ne_slot_adv;
                        ne_next      = ne_reg + 32'd1;
                        ne_slot_next = ne_slot_adv;
                        rel_cnt_next = rel_cnt_reg + RCNT_W'(1);
                        fwd_next     = 1'b0;
                    end
                end else if (out_free) begin
                    out_next      = pend_reg;
                    out_next.last = 1'b1;
                    m_valid_next  = 1'b1;
                    state_next    = ST_IDLE;
                end else begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE: begin
                if (out_free) begin
                    out_next      = pend_reg;
                    out_next.last = 1'b1;
                    m_valid_next  = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_CLEAR;
            clr_cnt_reg       <= '0;
            window_size_reg   <= WINDOW_RESET;
            ne_reg            <= '0;
            ne_slot_reg       <= '0;
            dropped_count_reg <= '0;
            rel_cnt_reg       <= '0;
            fwd_reg           <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg         <= state_next;
            clr_cnt_reg       <= clr_cnt_next;
            window_size_reg   <= window_size_next;
            ne_reg            <= ne_next;
            ne_slot_reg       <= ne_slot_next;
            dropped_count_reg <= dropped_count_next;
            rel_cnt_reg       <= rel_cnt_next;
            fwd_reg           <= fwd_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        slot_reg     <= slot_next;
        fwd_data_reg <= fwd_data_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        in_seq_reg   <= in_seq_next;
        in_stamp_reg <= in_stamp_next;
        in_after_reg <= in_after_next;
        in_ref_reg   <= in_ref_next;
        in_len_reg   <= in_len_next;
    end

    // ------------------------------------------------------------------
    // ports
    // ------------------------------------------------------------------
    assign cfg_ready       = 1'b1;
    assign m_valid         = m_valid_reg;
    assign m_ack_valid     = out_reg.ack_valid;
    assign m_ack_seq       = out_reg.ack_seq;
    assign m_ack_stamp     = out_reg.ack_stamp;
    assign m_deliver_valid = out_reg.deliver_valid;
    assign m_deliver_seq   = out_reg.deliver_seq;
    assign m_deliver_ref   = out_reg.deliver_ref;
    assign m_deliver_len   = out_reg.deliver_len;
    assign m_message_end   = out_reg.message_end;
    assign m_out_of_window = out_reg.out_of_window;
    assign m_duplicate     = out_reg.duplicate;
    assign m_last          = out_reg.last;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_drop_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_out_of_window |-> m_last && !m_ack_valid && !m_deliver_valid)
        else $error("dropped fragment word carries ack or release");

    a_rel_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        rel_cnt_reg <= RCNT_W'(MAX_RELEASE))
        else $error("release count past limit");

    a_ne_step: assert property (@(posedge aclk) disable iff (!aresetn)
        ne_reg != $past(ne_reg) |-> ne_reg == $past(ne_reg) + 32'd1)
        else $error("next expected moved by more than one");

    a_fwd_scope: assert property (@(posedge aclk) disable iff (!aresetn)
        fwd_reg |-> state_reg == ST_RELEASE && rel_cnt_reg == '0)
        else $error("bypass entry alive outside first release");

endmodule

FILE: tb/selective_repeat_receive_window_tb.sv
// ----------------------------------------------------------------------------
// selective_repeat_receive_window_tb: self-checking bench for the receive window
// Drives fragment descriptors and window size writes through valid/ready
// channels. A behavioral copy of the window predicts every result word, and
// a monitor compares each accepted word field by field, oldest first.
// ----------------------------------------------------------------------------
module selective_repeat_receive_window_tb;
    import srrw_pkg::*;

    // The limit sits well above the slowest legal run: ~110 fragments, each at
    // most 64 release words, each word waiting out the longest receiver stall.
    localparam int CYCLE_LIMIT   = 400000;
    // Wait after the last expected word; it covers a tail that grows with releases.
    localparam int SETTLE_CYCLES = 4 + MAX_RELEASE + 16;
    localparam int SLOTS         = WINDOW_DEPTH_DEF;

    logic               aclk            = 1'b0;
    logic               aresetn         = 1'b0;
    logic               cfg_valid       = 1'b0;
    logic               cfg_ready;
    logic [WIN_W-1:0]   cfg_window_size = '0;
    logic               s_valid         = 1'b0;
    logic               s_ready;
    logic [SEQ_W-1:0]   s_frag_seq      = '0;
    logic [STAMP_W-1:0] s_frag_stamp    = '0;
    logic [AFTER_W-1:0] s_frags_after   = '0;
    logic [PREF_W-1:0]  s_payload_ref   = '0;
    logic [PLEN_W-1:0]  s_payload_len   = '0;
    logic               m_valid;
    logic               m_ready         = 1'b0;
    logic               m_ack_valid;
    logic [SEQ_W-1:0]   m_ack_seq;
    logic [STAMP_W-1:0] m_ack_stamp;
    logic               m_deliver_valid;
    logic [SEQ_W-1:0]   m_deliver_seq;
    logic [PREF_W-1:0]  m_deliver_ref;
    logic [PLEN_W-1:0]  m_deliver_len;
    logic               m_message_end;
    logic               m_out_of_window;
    logic               m_duplicate;
    logic               m_last;

    // ---- window model: mirrors the block's architectural state ----
    logic [WIN_W-1:0]  window_cfg = WINDOW_RESET;  // as last written
    logic [SEQ_W-1:0]  seq_next   = '0;            // next sequence due for release
    logic [SLOTS-1:0]  slot_full  = '0;            // present marks, cleared at reset
    logic [PREF_W-1:0] slot_ref [SLOTS];
    logic [PLEN_W-1:0] slot_len [SLOTS];
    logic              slot_end [SLOTS];

    srrw_res_t due_words[$];   // result words still owed by the block, oldest first
    int        errors    = 0;
    bit        calm      = 1'b0; // both sides run back to back when set
    int        hold_off  = 0;    // receiver hold-off request, in cycles
    int unsigned cycle_count = 0;

    selective_repeat_receive_window dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_window_size (cfg_window_size),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_frag_seq      (s_frag_seq),
        .s_frag_stamp    (s_frag_stamp),
        .s_frags_after   (s_frags_after),
        .s_payload_ref   (s_payload_ref),
        .s_payload_len   (s_payload_len),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_ack_valid     (m_ack_valid),
        .m_ack_seq       (m_ack_seq),
        .m_ack_stamp     (m_ack_stamp),
        .m_deliver_valid (m_deliver_valid),
        .m_deliver_seq   (m_deliver_seq),
        .m_deliver_ref   (m_deliver_ref),
        .m_deliver_len   (m_deliver_len),
        .m_message_end   (m_message_end),
        .m_out_of_window (m_out_of_window),
        .m_duplicate     (m_duplicate),
        .m_last          (m_last)
    );

    always #2 aclk = ~aclk;

    // Run guard: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("selective_repeat_receive_window: mismatch");
            $finish;
        end
    end

    // Window in effect: anything above the store depth is clipped to it.
    function automatic int active_window();
        return (window_cfg > SLOTS) ? SLOTS : int'(window_cfg);
    endfunction

    // Append one owed word at the tail of the expected list.
    task automatic owe_word(input srrw_res_t w);
        due_words = {due_words, w};
    endtask

    // Predict the result words of one accepted fragment and update the model.
    // Word 0 carries the status flags, any ack and the first release; each
    // further release gets a word of its own. last marks the final word.
    task automatic predict_fragment(input logic [SEQ_W-1:0]   seq,
                                    input logic [STAMP_W-1:0] stamp,
                                    input logic [AFTER_W-1:0] after,
                                    input logic [PREF_W-1:0]  pref,
                                    input logic [PLEN_W-1:0]  plen);
        srrw_res_t     word;
        logic [SEQ_W:0] span;
        logic [SEQ_W:0] win_end;
        int            n;
        int unsigned   slot;
        word = '0;
        span = (SEQ_W+1)'(active_window());
        // window end is formed one bit wider, so it never wraps
        win_end = {1'b0, seq_next} + span;
        if ({1'b0, seq} >= win_end) begin
            // beyond the window: dropped, no ack, no release
            word.out_of_window = 1'b1;
            word.last          = 1'b1;
            owe_word(word);
        end else begin
            word.ack_valid = 1'b1;
            word.ack_seq   = seq;
            word.ack_stamp = stamp;
            if (seq < seq_next) begin
                // already released: ack again, store nothing
                word.duplicate = 1'b1;
                word.last      = 1'b1;
                owe_word(word);
            end else begin
                slot = seq % SLOTS;
                if (slot_full[slot]) begin
                    word.duplicate = 1'b1;
                end else begin
                    slot_full[slot] = 1'b1;
                    slot_ref[slot]  = pref;
                    slot_len[slot]  = plen;
                    slot_end[slot]  = (after == '0);
                end
                // in-order release from the head of the window
                n = 0;
                while (n < MAX_RELEASE && slot_full[seq_next % SLOTS]) begin
                    if (n > 0) begin
                        owe_word(word);
                        word = '0;
                    end
                    slot = seq_next % SLOTS;
                    word.deliver_valid = 1'b1;
                    word.deliver_seq   = seq_next;
                    word.deliver_ref   = slot_ref[slot];
                    word.deliver_len   = slot_len[slot];
                    word.message_end   = slot_end[slot];
                    slot_full[slot]    = 1'b0;
                    seq_next           = seq_next + 1'b1;
                    n++;
                end
                word.last = 1'b1;
                owe_word(word);
            end
        end
    endtask

    // ---- result side ----
    task automatic match_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endtask

    task automatic check_word();
        srrw_res_t want;
        if (due_words.size() == 0) begin
            $error("result word with nothing expected (deliver_seq 0x%0h)", m_deliver_seq);
            errors++;
        end else begin
            want = due_words.pop_front();
            match_field("ack_valid",     64'(want.ack_valid),     64'(m_ack_valid));
            match_field("ack_seq",       64'(want.ack_seq),       64'(m_ack_seq));
            match_field("ack_stamp",     64'(want.ack_stamp),     64'(m_ack_stamp));
            match_field("deliver_valid", 64'(want.deliver_valid), 64'(m_deliver_valid));
            match_field("deliver_seq",   64'(want.deliver_seq),   64'(m_deliver_seq));
            match_field("deliver_ref",   64'(want.deliver_ref),   64'(m_deliver_ref));
            match_field("deliver_len",   64'(want.deliver_len),   64'(m_deliver_len));
            match_field("message_end",   64'(want.message_end),   64'(m_message_end));
            match_field("out_of_window", 64'(want.out_of_window), 64'(m_out_of_window));
            match_field("duplicate",     64'(want.duplicate),     64'(m_duplicate));
            match_field("last",          64'(want.last),          64'(m_last));
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            check_word();
        end
    end

    // Receiver: random stall before each word, plus a long
    // hold-off on request. Each m_ready drive lands in its own time step.
    initial begin
        int stall;
        forever begin
            if (hold_off > 0) begin
                m_ready <= 1'b0;
                repeat (hold_off) @(posedge aclk);
                hold_off = 0;
            end
            stall = calm ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid && hold_off == 0);
        end
    end

    // ---- input side ----
    // Send one fragment word. valid stays up across back-to-back words, so it
    // is only lowered when a gap follows.
    task automatic send_fragment(input logic [SEQ_W-1:0]   seq,
                                 input logic [STAMP_W-1:0] stamp,
                                 input logic [AFTER_W-1:0] after,
                                 input logic [PREF_W-1:0]  pref,
                                 input logic [PLEN_W-1:0]  plen);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_frag_seq    <= seq;
        s_frag_stamp  <= stamp;
        s_frags_after <= after;
        s_payload_ref <= pref;
        s_payload_len <= plen;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_fragment(seq, stamp, after, pref, plen);
    endtask

    // Fragment with random content; frags_after is zero about a quarter of
    // the time so message ends show up often.
    task automatic send_seq(input logic [SEQ_W-1:0] seq);
        send_fragment(seq, STAMP_W'($urandom),
                      ($urandom_range(0, 3) == 0) ? '0 : AFTER_W'($urandom_range(0, 255)),
                      PREF_W'($urandom), PLEN_W'($urandom));
    endtask

    task automatic drain();
        while (due_words.size() != 0) @(posedge aclk);
    endtask

    task automatic finish_phase();
        s_valid <= 1'b0;
        drain();
    endtask

    // Window size write, only with the block idle (nothing owed).
    task automatic write_window(input logic [WIN_W-1:0] size);
        drain();
        cfg_valid       <= 1'b1;
        cfg_window_size <= size;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid  <= 1'b0;
        window_cfg  = size;
    endtask

    // ---- tests ----
    // Field extremes, in-order release, stored duplicate, repeat below the
    // window, window edge and drops far above it.
    task automatic test_directed();
        send_fragment(seq_next, '0, '0, '1, '1);              // head: release at once
        send_fragment(seq_next + 1, '1, '1, '0, '0);          // hole before it: stored
        send_fragment(seq_next + 1, 32'h1234_5678, 8'd7, 16'h00ff, 11'd5); // stored duplicate
        send_fragment(seq_next, 32'h8000_0001, 8'd1, 16'h8001, 11'h400); // fills hole
        send_seq(seq_next - 3);                               // repeat below window
        send_seq(seq_next + 64);                              // first seq past window
        send_seq(seq_next + 63);                              // last seq in window
        send_seq('1);                                         // top of sequence space
        send_seq(32'h8000_0000);
        send_seq(seq_next);
        finish_phase();
    endtask

    // Zero window, single-slot window, window above store depth.
    task automatic test_window_limits();
        write_window('0);
        send_seq(seq_next);                                   // zero window drops head
        send_seq(seq_next - 1);                               // repeat still acked
        send_seq(seq_next + 5);
        finish_phase();
        write_window(7'd1);
        send_seq(seq_next + 1);                               // past a one-slot window
        send_seq(seq_next);
        finish_phase();
        write_window('1);                                     // 127 clips to depth
        send_seq(seq_next + 63);
        send_seq(seq_next + 64);
        finish_phase();
        write_window(7'd100);
        send_seq(seq_next + 64);
        send_seq(seq_next + 10);
        finish_phase();
        write_window(7'd64);
        send_seq(seq_next + 62);
        finish_phase();
    endtask

    // Fill the whole window out of order, then the head: a 64-word burst.
    // Runs with no idling on either side.
    task automatic test_full_window_release();
        int offs [SLOTS-1];
        int pick;
        int tmp;
        for (int k = 0; k < SLOTS - 1; k++) offs[k] = k + 1;
        for (int k = SLOTS - 2; k > 0; k--) begin
            pick       = $urandom_range(0, k);
            tmp        = offs[k];
            offs[k]    = offs[pick];
            offs[pick] = tmp;
        end
        calm = 1'b1;
        for (int k = 0; k < SLOTS - 1; k++) send_seq(seq_next + offs[k]);
        send_seq(seq_next);
        finish_phase();
        calm = 1'b0;
    endtask

    // Receiver stops for a long stretch while in-order fragments keep coming:
    // the output register fills and the block holds off its input.
    task automatic test_back_pressure();
        hold_off = 300;
        for (int k = 0; k < 8; k++) send_seq(seq_next);
        finish_phase();
    endtask

    // Phases of mostly in-window traffic with random content, some repeats,
    // some just past the window and some full-range noise.
    task automatic test_random_traffic();
        int               win;
        int               span;
        int               roll;
        logic [SEQ_W-1:0] seq;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: write_window(7'd64);
                1: write_window(WIN_W'($urandom_range(1, 127)));
                2: write_window(WIN_W'($urandom_range(1, 16)));
                default: write_window(WIN_W'($urandom_range(1, 127)));
            endcase
            win = active_window();
            for (int k = 0; k < 5; k++) begin
                roll = $urandom_range(0, 99);
                if (roll < 65) begin
                    // near the head most of the time so releases happen often
                    span = (roll < 50 && win > 4) ? 4 : win;
                    seq  = seq_next + $urandom_range(0, span - 1);
                end else if (roll < 75) begin
                    seq = seq_next - $urandom_range(1, 8);
                end else if (roll < 85) begin
                    seq = seq_next + win + $urandom_range(0, 8);
                end else begin
                    seq = $urandom;
                end
                send_seq(seq);
            end
            finish_phase();
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_window_limits();
        test_full_window_release();
        test_back_pressure();
        test_random_traffic();
        drain();
        // catch stray words after the last expected one
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (errors == 0 && due_words.size() == 0) begin
            $display("selective_repeat_receive_window: match");
        end else begin
            $display("selective_repeat_receive_window: mismatch");
        end
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/srrw_pkg.sv
hw/rtl/selective_repeat_receive_window.sv
tb/selective_repeat_receive_window_tb.sv
